// ===== hdl/sst_pkg.sv =====
// Shared constants and types for the sorted sequence table search block.
package sst_pkg;

  // Fixed field widths of the stream and register interfaces.
  localparam int IDX_W    = 10;
  localparam int LEN_W    = 4;
  localparam int TPL_W    = 7;
  localparam int TPL_IX_W = 3;
  localparam int CFG_W    = 11;
  localparam int OUT_W    = 8;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  // Default sizes handed to the top level.
  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int DEF_MAX_LEN     = 8;
  localparam int DEF_ITEM_BITS   = 16;

  // Register index of entry_count.
  localparam logic [APB_AW-3:0] REG_ENTRY_COUNT = '0;

  // Outcome of one probe compare: entry below query, or equal.
  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

endpackage

// ===== hdl/sst_ram.sv =====
// Generic simple dual-port RAM with a registered read port.
module sst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/sst_cmp.sv =====
// Order compare between one table row and the query row.
module sst_cmp
  import sst_pkg::*;
#(
  parameter int MAX_LEN   = DEF_MAX_LEN,
  parameter int ITEM_BITS = DEF_ITEM_BITS
) (
  input  logic [LEN_W+TPL_W+MAX_LEN*ITEM_BITS-1:0] entry_row,
  input  logic [LEN_W+TPL_W+MAX_LEN*ITEM_BITS-1:0] query_row,
  output cmp_res_t                                 res
);

  localparam int CW = ITEM_BITS + 1;
  localparam int KW = LEN_W + ITEM_BITS + (MAX_LEN - 1) * CW;
  localparam int IT0 = LEN_W + TPL_W;

  logic [LEN_W-1:0] qlen;
  logic [TPL_W-1:0] etpl;
  logic [TPL_W-1:0] qtpl;
  logic [KW-1:0]    ekey;
  logic [KW-1:0]    qkey;

  assign qlen = query_row[LEN_W-1:0];
  assign etpl = entry_row[LEN_W +: TPL_W];
  assign qtpl = query_row[LEN_W +: TPL_W];

  // A longer sequence sorts lower, so the length enters the key inverted.
  // Later positions are masked by the query length; they only matter once
  // the lengths already match.
  assign ekey[KW-1 -: LEN_W] = ~entry_row[LEN_W-1:0];
  assign qkey[KW-1 -: LEN_W] = ~qlen;
  assign ekey[KW-LEN_W-1 -: ITEM_BITS] = entry_row[IT0 +: ITEM_BITS];
  assign qkey[KW-LEN_W-1 -: ITEM_BITS] = query_row[IT0 +: ITEM_BITS];

  for (genvar i = 1; i < MAX_LEN; i++) begin : g_pos
    logic             used;
    logic [LEN_W-1:0] pos;
    logic             ebit;
    logic             qbit;

    assign used = LEN_W'(i) < qlen;
    assign pos  = qlen - LEN_W'(i + 1);
    assign ebit = (pos < LEN_W'(TPL_W)) ? etpl[pos[TPL_IX_W-1:0]] : 1'b0;
    assign qbit = (pos < LEN_W'(TPL_W)) ? qtpl[pos[TPL_IX_W-1:0]] : 1'b0;

    assign ekey[(MAX_LEN-1-i)*CW +: CW] =
      used ? {ebit, entry_row[IT0+i*ITEM_BITS +: ITEM_BITS]} : '0;
    assign qkey[(MAX_LEN-1-i)*CW +: CW] =
      used ? {qbit, query_row[IT0+i*ITEM_BITS +: ITEM_BITS]} : '0;
  end

  assign res.lt = ekey < qkey;
  assign res.eq = ekey == qkey;

endmodule

// ===== hdl/sorted_sequence_table_search.sv =====
// Sorted sequence table: a write beat (tuser 0) stores one entry on its
// accepted beat and gives no result; a query beat (tuser 1) runs a binary
// search over entries 0 to entry_count-1, with entry_count capped at
// TABLE_DEPTH, and returns one found beat. Each probe is one read of the
// single-port-read table RAM in ST_PROBE and one pass through the shared
// order comparator in ST_CMP. ST_FIN holds while the previous found beat
// still waits for m_axis_tready. The input is not ready while a query is in
// progress. Entries are kept in table order by software; a query must only
// reach entries already written.
module sorted_sequence_table_search
  import sst_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int MAX_LEN     = DEF_MAX_LEN,
  parameter int ITEM_BITS   = DEF_ITEM_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  // entry_index, seq_len, template_bits, item_0 .. item_(MAX_LEN-1), zero pad
  input  logic [((IDX_W+LEN_W+TPL_W+MAX_LEN*ITEM_BITS+7)/8)*8-1:0] s_axis_tdata,
  // mode
  input  logic [0:0]               s_axis_tuser,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // found, zero pad
  output logic [OUT_W-1:0]         m_axis_tdata,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_AW-1:0]        paddr,
  input  logic [APB_DW-1:0]        pwdata,
  output logic [APB_DW-1:0]        prdata,
  output logic                     pready
);

  localparam int AW   = $clog2(TABLE_DEPTH);
  localparam int RW   = LEN_W + TPL_W + MAX_LEN * ITEM_BITS;
  localparam int PW   = AW + 2;
  localparam int IXW  = (IDX_W > AW + 1) ? IDX_W : AW + 1;
  localparam int CNW  = (CFG_W > AW + 1) ? CFG_W : AW + 1;
  localparam logic [IXW-1:0] DEPTH_IX = IXW'(TABLE_DEPTH);
  localparam logic [CNW-1:0] DEPTH_CN = CNW'(TABLE_DEPTH);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_PROBE = 2'd1;
  localparam logic [1:0] ST_CMP   = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]         state;
  logic [CFG_W-1:0]   entry_count;
  logic [RW-1:0]      q_row;
  logic signed [PW-1:0] lo;
  logic signed [PW-1:0] hi;
  logic [AW-1:0]      mid;
  logic               hit;
  logic               found;
  logic               found_valid;

  logic               in_fire;
  logic               cfg_wr;
  logic [IXW-1:0]     wr_idx;
  logic               wr_en;
  logic [CNW-1:0]     cnt_ext;
  logic [CNW-1:0]     cnt_cl;
  logic [PW-1:0]      mid_sum;
  logic [AW-1:0]      mid_next;
  logic [RW-1:0]      ram_rdata;
  cmp_res_t           cmp_res;

  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = found_valid;
  assign m_axis_tdata  = {(OUT_W-1)'(0), found};

  // Configuration port: one register, ignoring the byte offset bits.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[APB_AW-1:2] == REG_ENTRY_COUNT);
  assign prdata = (paddr[APB_AW-1:2] == REG_ENTRY_COUNT) ?
                  APB_DW'(entry_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_wr) begin
      entry_count <= pwdata[CFG_W-1:0];
    end
  end

  // Table writes go straight to the RAM on the accepted beat.
  assign wr_idx = IXW'(s_axis_tdata[IDX_W-1:0]);
  assign wr_en  = in_fire && !s_axis_tuser[0] && (wr_idx < DEPTH_IX);

  assign cnt_ext  = CNW'(entry_count);
  assign cnt_cl   = (cnt_ext > DEPTH_CN) ? DEPTH_CN : cnt_ext;
  assign mid_sum  = lo + hi;
  assign mid_next = mid_sum[AW:1];

  sst_ram #(
    .WIDTH(RW),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_idx[AW-1:0]),
    .wdata(s_axis_tdata[IDX_W +: RW]),
    .raddr(mid_next),
    .rdata(ram_rdata)
  );

  sst_cmp #(
    .MAX_LEN  (MAX_LEN),
    .ITEM_BITS(ITEM_BITS)
  ) u_cmp (
    .entry_row(ram_rdata),
    .query_row(q_row),
    .res      (cmp_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      found_valid <= 1'b0;
    end else begin
      // A new result may load in the same cycle that the previous one leaves.
      if (state == ST_FIN && (!found_valid || m_axis_tready)) begin
        found_valid <= 1'b1;
      end else if (found_valid && m_axis_tready) begin
        found_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire && s_axis_tuser[0]) begin
            state <= ST_PROBE;
          end
        end
        ST_PROBE: begin
          if (lo > hi) begin
            state <= ST_FIN;
          end else begin
            state <= ST_CMP;
          end
        end
        ST_CMP: begin
          if (cmp_res.eq) begin
            state <= ST_FIN;
          end else begin
            state <= ST_PROBE;
          end
        end
        ST_FIN: begin
          if (!found_valid || m_axis_tready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Search bounds, query copy and result payload.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_fire && s_axis_tuser[0]) begin
          q_row <= s_axis_tdata[IDX_W +: RW];
          lo    <= '0;
          hi    <= $signed({1'b0, cnt_cl[AW:0]}) - PW'(1);
          hit   <= 1'b0;
        end
      end
      ST_PROBE: begin
        mid <= mid_next;
      end
      ST_CMP: begin
        if (cmp_res.eq) begin
          hit <= 1'b1;
        end else if (cmp_res.lt) begin
          hi <= $signed({2'b00, mid}) - PW'(1);
        end else begin
          lo <= $signed({2'b00, mid}) + PW'(1);
        end
      end
      ST_FIN: begin
        if (!found_valid || m_axis_tready) begin
          found <= hit;
        end
      end
      default: begin
        hit <= hit;
      end
    endcase
  end

endmodule

// ===== sim/tb_top.sv =====
// Self-checking stream and register testbench for the sorted sequence table search block.
`timescale 1ns / 100ps

module tb_top
  import sst_pkg::*;
;

  localparam int TABLE_DEPTH   = DEF_TABLE_DEPTH;
  localparam int MAX_LEN       = DEF_MAX_LEN;
  localparam int ITEM_BITS     = DEF_ITEM_BITS;
  localparam int TDATA_W       = ((IDX_W + LEN_W + TPL_W + MAX_LEN * ITEM_BITS + 7) / 8) * 8;
  localparam int SETTLE_CYCLES = 32;
  localparam int RUN_LIMIT_NS  = 4_000_000;
  localparam logic [APB_AW-1:0] ENTRY_COUNT_ADDR = {REG_ENTRY_COUNT, 2'b00};

  typedef enum logic {
    MODE_WRITE = 1'b0,
    MODE_QUERY = 1'b1
  } beat_mode_t;

  // One table entry as it sits in tdata, slot in the lowest bits.
  typedef struct packed {
    logic [MAX_LEN-1:0][ITEM_BITS-1:0] items;
    logic [TPL_W-1:0]                  tpl;
    logic [LEN_W-1:0]                  len;
    logic [IDX_W-1:0]                  slot;
  } entry_fields_t;

  typedef struct packed {
    beat_mode_t    mode;
    entry_fields_t f;
  } seq_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic [TDATA_W-1:0] s_axis_tdata  = '0;
  logic [0:0]         s_axis_tuser  = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [OUT_W-1:0]   m_axis_tdata;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [APB_AW-1:0]  paddr   = '0;
  logic [APB_DW-1:0]  pwdata  = '0;
  logic [APB_DW-1:0]  prdata;
  logic               pready;

  sorted_sequence_table_search #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .MAX_LEN    (MAX_LEN),
    .ITEM_BITS  (ITEM_BITS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state: table contents and entry_count as the block should hold them.
  entry_fields_t     seq_table [TABLE_DEPTH];
  logic [CFG_W-1:0]  cfg_entry_count = '0;
  logic              found_expected [$];

  // Stimulus side: what the table will hold once every queued beat is in.
  entry_fields_t     plan_table [TABLE_DEPTH];
  seq_beat_t         pending_beats [$];
  seq_beat_t         held_beat;
  int                outstanding_beats = 0;
  bit                idle_on = 1'b1;
  int                send_gap = 0;
  int                stall_left = 0;

  int                mismatch_count = 0;
  int                write_beats = 0;
  int                query_beats = 0;
  int                found_hits = 0;
  int                cfg_writes = 0;
  logic              found_want;

  task automatic report_mismatch(string what, logic [APB_DW-1:0] got, logic [APB_DW-1:0] want);
    $display("%0t: mismatch: %s, got %0h, want %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Order of entries: a longer sequence is smaller, then item 0, then for each
  // later position the template bit at len-1-i followed by item i.
  function automatic cmp_res_t entry_vs_query(entry_fields_t e, entry_fields_t q);
    cmp_res_t r;
    int       n;
    int       i;
    int       pos;
    logic     be;
    logic     bq;
    r = '0;
    if (e.len != q.len) begin
      r.lt = (e.len > q.len);
      return r;
    end
    if (e.items[0] != q.items[0]) begin
      r.lt = (e.items[0] < q.items[0]);
      return r;
    end
    n = (e.len < MAX_LEN) ? int'(e.len) : MAX_LEN;
    for (i = 1; i < n; i++) begin
      pos = int'(e.len) - 1 - i;
      be = (pos < TPL_W) ? e.tpl[pos] : 1'b0;
      bq = (pos < TPL_W) ? q.tpl[pos] : 1'b0;
      if (be != bq) begin
        r.lt = (be < bq);
        return r;
      end
      if (e.items[i] != q.items[i]) begin
        r.lt = (e.items[i] < q.items[i]);
        return r;
      end
    end
    r.eq = 1'b1;
    return r;
  endfunction

  function automatic logic search_found(entry_fields_t q);
    int       lo;
    int       hi;
    int       mid;
    cmp_res_t r;
    lo = 0;
    hi = ((cfg_entry_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(cfg_entry_count)) - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      r = entry_vs_query(seq_table[mid], q);
      if (r.eq) return 1'b1;
      if (r.lt) hi = mid - 1;
      else lo = mid + 1;
    end
    return 1'b0;
  endfunction

  function automatic void absorb_beat(seq_beat_t b);
    if (b.mode == MODE_WRITE) seq_table[b.f.slot] = b.f;
    else found_expected.push_back(search_found(b.f));
  endfunction

  function automatic logic [ITEM_BITS-1:0] random_item();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2, 3: return ITEM_BITS'($urandom_range(0, 3));
      default: return ITEM_BITS'($urandom);
    endcase
  endfunction

  function automatic entry_fields_t random_entry();
    entry_fields_t e;
    int            pick;
    int            i;
    e = '0;
    pick = $urandom_range(0, 19);
    if (pick == 0) e.len = '0;
    else if (pick < 3) e.len = LEN_W'($urandom_range(9, 15));
    else e.len = LEN_W'($urandom_range(1, MAX_LEN));
    e.tpl = TPL_W'($urandom_range(0, 127));
    for (i = 0; i < MAX_LEN; i++) e.items[i] = random_item();
    e.slot = IDX_W'($urandom);
    return e;
  endfunction

  function automatic entry_fields_t make_entry(logic [LEN_W-1:0] len, logic [TPL_W-1:0] tpl,
                                               logic [ITEM_BITS-1:0] first,
                                               logic [ITEM_BITS-1:0] rest);
    entry_fields_t e;
    int            i;
    e = '0;
    e.len = len;
    e.tpl = tpl;
    e.items[0] = first;
    for (i = 1; i < MAX_LEN; i++) e.items[i] = rest;
    return e;
  endfunction

  // Half hits with the ignored fields scrambled, then near misses, then noise.
  function automatic entry_fields_t pick_query(int span);
    entry_fields_t q;
    int            kind;
    int            n;
    int            k;
    int            ln;
    int            pos;
    q = random_entry();
    kind = $urandom_range(0, 9);
    if (span > 0 && kind < 5) begin
      q = plan_table[$urandom_range(0, span - 1)];
      ln = int'(q.len);
      n = (ln < MAX_LEN) ? ln : MAX_LEN;
      if (n < 1) n = 1;
      for (k = n; k < MAX_LEN; k++) begin
        if ($urandom_range(0, 1) == 1) q.items[k] = random_item();
      end
      for (pos = 0; pos < TPL_W; pos++) begin
        if ((pos > ln - 2 || pos < ln - n) && $urandom_range(0, 1) == 1) q.tpl[pos] = ~q.tpl[pos];
      end
    end else if (span > 0 && kind < 8) begin
      q = plan_table[$urandom_range(0, span - 1)];
      case ($urandom_range(0, 3))
        0: q.len = q.len + 1'b1;
        1: begin
          k = $urandom_range(0, ITEM_BITS - 1);
          q.items[0][k] = ~q.items[0][k];
        end
        2: begin
          k = $urandom_range(1, MAX_LEN - 1);
          q.items[k] = q.items[k] + 1'b1;
        end
        default: begin
          k = $urandom_range(0, TPL_W - 1);
          q.tpl[k] = ~q.tpl[k];
        end
      endcase
    end
    q.slot = IDX_W'($urandom);
    return q;
  endfunction

  task automatic queue_write(int slot, entry_fields_t f);
    seq_beat_t b;
    f.slot = IDX_W'(slot);
    plan_table[slot] = f;
    b.mode = MODE_WRITE;
    b.f = f;
    pending_beats.push_back(b);
    outstanding_beats++;
    write_beats++;
  endtask

  task automatic queue_query(entry_fields_t f);
    seq_beat_t b;
    f.slot = IDX_W'($urandom);
    b.mode = MODE_QUERY;
    b.f = f;
    pending_beats.push_back(b);
    outstanding_beats++;
    query_beats++;
  endtask

  // Fills slots 0..n-1, largest entry first when sorted, in either slot order.
  task automatic queue_table(int n, bit sorted);
    entry_fields_t key;
    cmp_res_t      r;
    int            i;
    int            j;
    bit            descending;
    for (i = 0; i < n; i++) begin
      key = random_entry();
      j = i - 1;
      while (sorted && j >= 0) begin
        r = entry_vs_query(plan_table[j], key);
        if (!r.lt) break;
        plan_table[j + 1] = plan_table[j];
        j--;
      end
      plan_table[j + 1] = key;
    end
    descending = $urandom_range(0, 1);
    for (i = 0; i < n; i++) begin
      j = descending ? n - 1 - i : i;
      queue_write(j, plan_table[j]);
    end
  endtask

  task automatic run_queries(int n_queries, int span);
    int i;
    for (i = 0; i < n_queries; i++) begin
      if ($urandom_range(0, 24) == 0) begin
        if (span < TABLE_DEPTH) queue_write($urandom_range(span, TABLE_DEPTH - 1), random_entry());
        else queue_write($urandom_range(0, TABLE_DEPTH - 1), random_entry());
      end
      queue_query(pick_query(span));
    end
  endtask

  // Returns once every queued beat is in, every result is out, and the block
  // has had time to finish a trailing write.
  task automatic wait_drained();
    do @(posedge clk); while (outstanding_beats != 0 || found_expected.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic program_entry_count(logic [CFG_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ENTRY_COUNT_ADDR;
    pwdata  <= APB_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== APB_DW'(value)) report_mismatch("entry_count read back", prdata, APB_DW'(value));
    psel    <= 1'b0;
    penable <= 1'b0;
    cfg_entry_count = value;
    cfg_writes++;
    @(negedge clk);
  endtask

  task automatic run_table_phase(int count_value, int n_fill, bit sorted, int n_queries);
    if (n_fill > 0) queue_table(n_fill, sorted);
    wait_drained();
    program_entry_count(CFG_W'(count_value));
    run_queries(n_queries, (count_value > TABLE_DEPTH) ? TABLE_DEPTH : count_value);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        absorb_beat(held_beat);
        outstanding_beats--;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_beats.size() != 0) begin
          held_beat = pending_beats.pop_front();
          s_axis_tdata  <= TDATA_W'(held_beat.f);
          s_axis_tuser  <= held_beat.mode;
          s_axis_tvalid <= 1'b1;
          if (idle_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 17);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (found_expected.size() == 0) begin
          report_mismatch("found beat with no query waiting", APB_DW'(m_axis_tdata), '0);
        end else begin
          found_want = found_expected.pop_front();
          if (m_axis_tdata !== {{(OUT_W - 1){1'b0}}, found_want})
            report_mismatch("found flag", APB_DW'(m_axis_tdata), APB_DW'(found_want));
          if (found_want) found_hits++;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (idle_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 17);
      end
    end
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    entry_fields_t d [6];
    entry_fields_t q;
    int            i;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Empty table straight out of reset.
    queue_query(make_entry(4'd15, 7'h7F, 16'hFFFF, 16'hFFFF));

    // Small sorted table: zero length, template tie break, overlong length.
    d[0] = make_entry(4'd0,  7'h55, 16'hFFFF, 16'h0000);
    d[1] = make_entry(4'd1,  7'h00, 16'hFFFF, 16'hFFFF);
    d[2] = make_entry(4'd2,  7'h01, 16'h1234, 16'hFFFF);
    d[3] = make_entry(4'd2,  7'h00, 16'h1234, 16'hFFFF);
    d[4] = make_entry(4'd8,  7'h7F, 16'hFFFF, 16'hFFFF);
    d[5] = make_entry(4'd15, 7'h00, 16'h0000, 16'h0000);
    queue_write(TABLE_DEPTH - 1, d[4]);
    for (i = 5; i >= 0; i--) queue_write(i, d[i]);
    wait_drained();
    program_entry_count(CFG_W'(6));
    for (i = 0; i < 6; i++) queue_query(d[i]);
    q = make_entry(4'd0, 7'h2A, 16'hFFFF, 16'h5A5A);
    queue_query(q);
    q = d[3];
    q.tpl = 7'h7E;
    queue_query(q);
    q = d[5];
    q.tpl = 7'h7F;
    queue_query(q);
    q = d[2];
    q.items[1] = 16'hFFFE;
    queue_query(q);
    q = d[1];
    q.len = 4'd9;
    queue_query(q);
    q = d[4];
    q.items[MAX_LEN - 1] = 16'h7FFF;
    queue_query(q);
    q = d[4];
    q.tpl = 7'h3F;
    queue_query(q);

    run_table_phase(TABLE_DEPTH, TABLE_DEPTH, 1'b1, 12);
    run_table_phase(TABLE_DEPTH - 1, 0, 1'b0, 5);
    run_table_phase(2047, 0, 1'b0, 5);
    run_table_phase(1500, 0, 1'b0, 4);
    // Leading slices of the sorted full table are sorted tables of their own.
    run_table_phase(40, 0, 1'b0, 4);
    run_table_phase(13, 0, 1'b0, 4);
    run_table_phase(6, 0, 1'b0, 3);
    run_table_phase(3, 0, 1'b0, 3);
    run_table_phase(2, 0, 1'b0, 3);
    run_table_phase(1, 0, 1'b0, 3);
    run_table_phase(8, 8, 1'b0, 4);
    run_table_phase(0, 0, 1'b0, 3);
    idle_on = 1'b0;
    run_table_phase(TABLE_DEPTH, 0, 1'b0, 15);
    wait_drained();

    $display("tb_top: %0d table writes, %0d queries, %0d of them found", write_beats,
             query_beats, found_hits);
    $display("tb_top: %0d entry_count settings from 0 to 2047, sorted and unsorted tables",
             cfg_writes);
    if (mismatch_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
